@@ rtl/core/i2cme_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cme_pkg
// Types, codes and reset constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cme_pkg;

    localparam int FUNC_W    = 3;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int HALF_W    = 16;
    localparam int LIMIT_W   = 8;
    localparam int BITCNT_W  = 4;

    localparam logic [HALF_W-1:0]   HALF_RESET  = 16'd100;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 8'd20;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_LIMIT = 2'd1;

    typedef enum logic [11:0] {
        PH_IDLE    = 12'b0000_0000_0001,
        PH_START_A = 12'b0000_0000_0010,
        PH_START_B = 12'b0000_0000_0100,
        PH_STOP_A  = 12'b0000_0000_1000,
        PH_STOP_B  = 12'b0000_0001_0000,
        PH_WR_HI   = 12'b0000_0010_0000,
        PH_WR_LO   = 12'b0000_0100_0000,
        PH_RD_HI   = 12'b0000_1000_0000,
        PH_RD_LO   = 12'b0001_0000_0000,
        PH_CLR_HI  = 12'b0010_0000_0000,
        PH_CLR_LO  = 12'b0100_0000_0000,
        PH_CLR_STP = 12'b1000_0000_0000
    } t_phase;

    // one result beat, lowest field last
    typedef struct packed {
        logic       bus_freed;
        logic       ack_received;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } t_res;

endpackage

@@ rtl/core/i2c_master_byte_engine_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Tick-driven I2C master: start, stop, byte write/read and bus clear.
// ----------------------------------------------------------------------------
// Results: each accepted tick's result beat is registered in the output
//   register, or in the skid register while the output register is held.
// Throughput: one tick per cycle while the skid is empty; a two-entry output
//   (register plus skid) keeps the slave side open while one result waits.
// Reset (synchronous, active low): lines released, engine idle, held results
//   zero, half period 100 ticks, clear pulse limit 20.
module i2c_master_byte_engine_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: tx_byte[7:0], send_ack[8], sda_in[9], zero [15:10]
    input  logic [i2cme_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: func[2:0]
    input  logic [i2cme_pkg::FUNC_W-1:0]        i_s_tuser,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
    //        ack_received[12], bus_freed[13], zero [15:14]
    output logic [i2cme_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2cme_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [i2cme_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import i2cme_pkg::*;

    logic [HALF_W-1:0]   r_half;
    logic [LIMIT_W-1:0]  r_limit;

    t_phase              r_phase,  n_phase;
    logic [BITCNT_W-1:0] r_bit,    n_bit;
    logic [7:0]          r_shift,  n_shift;
    logic [HALF_W-1:0]   r_tick,   n_tick;
    logic [LIMIT_W-1:0]  r_pulse,  n_pulse;
    logic                r_ackm,   n_ackm;
    logic                r_scl,    n_scl;
    logic                r_sda,    n_sda;
    logic [7:0]          r_rx,     n_rx;
    logic                r_ackh,   n_ackh;
    logic                r_freed,  n_freed;

    t_res                r_out, r_skid, n_res;
    logic                r_out_valid, r_skid_valid;

    logic [FUNC_W-1:0]   func;
    logic [7:0]          tx_byte;
    logic                send_ack;
    logic                sda_in;
    logic                accept;
    logic                done;
    logic                fire;
    logic [HALF_W-1:0]   hp;
    logic [HALF_W-1:0]   tick_inc;
    logic [BITCNT_W-1:0] bit_inc;
    logic [7:0]          shift_rd;
    logic [7:0]          shift_wr;
    logic [LIMIT_W-1:0]  pulse_inc;

    assign func     = i_s_tuser;
    assign tx_byte  = i_s_tdata[7:0];
    assign send_ack = i_s_tdata[8];
    assign sda_in   = i_s_tdata[9];

    assign o_s_tready  = ~r_skid_valid;
    assign accept      = i_s_tvalid & o_s_tready;
    assign o_cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= HALF_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half  <= i_cfg_data[HALF_W-1:0];
                CFG_CLEAR_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign hp        = (r_half == '0) ? HALF_W'(1) : r_half;
    assign tick_inc  = r_tick + HALF_W'(1);
    assign fire      = (tick_inc >= hp);
    assign bit_inc   = r_bit + BITCNT_W'(1);
    assign shift_rd  = {r_shift[6:0], sda_in};
    assign shift_wr  = {r_shift[6:0], 1'b0};
    assign pulse_inc = r_pulse + LIMIT_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_tick  = r_tick;
        n_pulse = r_pulse;
        n_ackm  = r_ackm;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_ackh  = r_ackh;
        n_freed = r_freed;
        done    = 1'b0;

        if (r_phase == PH_IDLE) begin
            n_tick = '0;
            case (func)
                FUNC_START: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_phase = PH_START_A;
                end
                FUNC_STOP: begin
                    n_scl = 1'b1; n_sda = 1'b0; n_phase = PH_STOP_A;
                end
                FUNC_WRITE: begin
                    n_shift = tx_byte; n_bit = '0;
                    n_scl = 1'b0; n_sda = tx_byte[7]; n_phase = PH_WR_HI;
                end
                FUNC_READ: begin
                    n_shift = '0; n_bit = '0; n_ackm = send_ack;
                    n_scl = 1'b0; n_sda = 1'b1; n_phase = PH_RD_HI;
                end
                FUNC_CLEAR: begin
                    n_pulse = '0;
                    n_scl = 1'b0; n_sda = 1'b1; n_phase = PH_CLR_HI;
                end
                default: ;
            endcase
        end else if (!fire) begin
            n_tick = tick_inc;
        end else begin
            n_tick = '0;
            case (r_phase)
                PH_START_A: begin
                    n_sda = 1'b0; n_phase = PH_START_B;
                end
                PH_START_B: begin
                    n_scl = 1'b0; done = 1'b1;
                end
                PH_STOP_A: begin
                    n_sda = 1'b1; n_phase = PH_STOP_B;
                end
                PH_STOP_B: done = 1'b1;
                PH_WR_HI: begin
                    n_scl = 1'b1; n_phase = PH_WR_LO;
                end
                PH_RD_HI: begin
                    n_scl = 1'b1; n_phase = PH_RD_LO;
                end
                PH_WR_LO: begin
                    n_scl = 1'b0;
                    if (r_bit >= BITS_PER_BYTE) begin
                        n_ackh = ~sda_in; n_sda = 1'b1; done = 1'b1;
                    end else begin
                        n_bit   = bit_inc;
                        n_shift = shift_wr;
                        // ACK slot releases SDA
                        n_sda   = (bit_inc >= BITS_PER_BYTE) ? 1'b1 : shift_wr[7];
                        n_phase = PH_WR_HI;
                    end
                end
                PH_RD_LO: begin
                    n_scl = 1'b0;
                    if (r_bit >= BITS_PER_BYTE) begin
                        n_sda = 1'b1; done = 1'b1;
                    end else begin
                        n_shift = shift_rd;
                        n_bit   = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            n_rx  = shift_rd;
                            n_sda = ~r_ackm;
                        end else begin
                            n_sda = 1'b1;
                        end
                        n_phase = PH_RD_HI;
                    end
                end
                PH_CLR_HI: begin
                    n_scl = 1'b1; n_phase = PH_CLR_LO;
                end
                PH_CLR_LO: begin
                    n_pulse = pulse_inc;
                    n_scl   = 1'b0;
                    if (sda_in || (pulse_inc >= r_limit)) begin
                        n_freed = sda_in; n_sda = 1'b0; n_phase = PH_CLR_STP;
                    end else begin
                        n_phase = PH_CLR_HI;
                    end
                end
                PH_CLR_STP: begin
                    n_scl = 1'b1; n_sda = 1'b1; done = 1'b1;
                end
                default: done = 1'b1;
            endcase
            if (done) begin
                n_phase = PH_IDLE;
            end
        end

        n_res.scl_out      = n_scl;
        n_res.sda_out      = n_sda;
        n_res.busy_res     = (n_phase != PH_IDLE);
        n_res.done_res     = done;
        n_res.rx_byte      = n_rx;
        n_res.ack_received = n_ackh;
        n_res.bus_freed    = n_freed;
    end

    // engine state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_shift <= '0;
            r_tick  <= '0;
            r_pulse <= '0;
            r_ackm  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_rx    <= '0;
            r_ackh  <= 1'b0;
            r_freed <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_tick  <= n_tick;
            r_pulse <= n_pulse;
            r_ackm  <= n_ackm;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_rx    <= n_rx;
            r_ackh  <= n_ackh;
            r_freed <= n_freed;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || i_m_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || i_m_tready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - $bits(t_res)){1'b0}}, r_out};

endmodule
